// File: sv/lrupr_pkg.sv
// Shared constants, types and helpers for the LRU page replacement block.
// Used by the front, queue, back and top level modules; depends on nothing.
package lrupr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int RANK_W     = $clog2(MAX_FRAMES);
	localparam int ACT_W      = $clog2(MAX_FRAMES + 1);
	localparam int CNT_W      = 32;
	localparam int TREE_LVLS  = $clog2(MAX_FRAMES);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [FRAME_W-1:0]   frame_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ACT_W-1:0]     act_t;

	// Snapshot of the frame table, driven by the back end.
	typedef struct packed {
		logic [MAX_FRAMES-1:0]         valid;
		logic [MAX_FRAMES-1:0][PAGE_BITS-1:0] page;
		logic [MAX_FRAMES-1:0][RANK_W-1:0]    rank;
	} table_view_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		logic   hit;
		frame_t frame;
		logic   ev_valid;
		page_t  ev_page;
		page_t  page;
	} decision_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic frame_t lowest_set(input logic [MAX_FRAMES-1:0] vec);
		frame_t idx;
		idx = '0;
		for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
			if (vec[j]) idx = FRAME_W'(j);
		end
		return idx;
	endfunction

endpackage

// File: sv/lrupr_queue.sv
// Short decision queue between the front end and the back end.
// Depends on lrupr_pkg for the decision type and queue depth.
module lrupr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lrupr_pkg::decision_t push_data,
	input  logic                 pop,
	output lrupr_pkg::decision_t pop_data,
	output logic                 empty
);
	import lrupr_pkg::*;

	decision_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign empty    = (cnt_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: sv/lrupr_front.sv
// Front end: accepts page requests and classifies them against the frame table.
// Depends on lrupr_pkg; reads the table snapshot driven by lrupr_back.
module lrupr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lrupr_pkg::page_t       page,
	input  lrupr_pkg::act_t        frames_in_use,
	input  lrupr_pkg::table_view_t view,
	input  logic                   q_empty,
	output logic                   push,
	output lrupr_pkg::decision_t   push_data
);
	import lrupr_pkg::*;

	logic  pend_q;
	page_t page_s1;
	logic  accept;

	act_t                  act;
	logic [MAX_FRAMES-1:0] active;
	logic [MAX_FRAMES-1:0] hit_vec;
	logic [MAX_FRAMES-1:0] empty_vec;
	logic [RANK_W:0]       key  [MAX_FRAMES];
	frame_t                kidx [MAX_FRAMES];
	frame_t                hit_idx;
	frame_t                empty_idx;
	frame_t                old_idx;

	// The request is classified only once the queue has drained, so the
	// table it looks at already reflects every earlier request.
	assign push     = pend_q && q_empty;
	assign in_stall = pend_q && !q_empty;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (push) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) page_s1 <= page;
	end

	// Tag compare, empty search and oldest-frame tree over the active frames.
	always_comb begin
		if (frames_in_use == '0) act = ACT_W'(1);
		else if (frames_in_use > ACT_W'(MAX_FRAMES)) act = ACT_W'(MAX_FRAMES);
		else act = frames_in_use;

		for (int j = 0; j < MAX_FRAMES; j++) begin
			active[j]    = (ACT_W'(j) < act);
			hit_vec[j]   = active[j] && view.valid[j] && (view.page[j] == page_s1);
			empty_vec[j] = active[j] && !view.valid[j];
			key[j]       = {active[j], view.rank[j]};
			kidx[j]      = FRAME_W'(j);
		end

		// Pairwise maximum, the lower frame wins a tie.
		for (int lvl = 0; lvl < TREE_LVLS; lvl++) begin
			for (int i = 0; i < MAX_FRAMES; i += (2 << lvl)) begin
				if (i + (1 << lvl) < MAX_FRAMES) begin
					if (key[i + (1 << lvl)] > key[i]) begin
						key[i]  = key[i + (1 << lvl)];
						kidx[i] = kidx[i + (1 << lvl)];
					end
				end
			end
		end

		hit_idx   = lowest_set(hit_vec);
		empty_idx = lowest_set(empty_vec);
		old_idx   = kidx[0];

		push_data.hit      = |hit_vec;
		push_data.ev_valid = !(|hit_vec) && !(|empty_vec);
		push_data.page     = page_s1;
		if (|hit_vec) push_data.frame = hit_idx;
		else if (|empty_vec) push_data.frame = empty_idx;
		else push_data.frame = old_idx;
		push_data.ev_page = push_data.ev_valid ? view.page[old_idx] : '0;
	end

endmodule

// File: sv/lrupr_back.sv
// Back end: holds the frame table, applies each decision and drives results.
// Depends on lrupr_pkg; takes decisions from lrupr_queue.
module lrupr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  lrupr_pkg::decision_t   pop_data,
	output logic                   pop,
	output lrupr_pkg::table_view_t view,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output lrupr_pkg::frame_t      frame_index,
	output logic                   evicted_valid,
	output lrupr_pkg::page_t       evicted_page,
	output lrupr_pkg::cnt_t        hit_count,
	output lrupr_pkg::cnt_t        fault_count
);
	import lrupr_pkg::*;

	logic [MAX_FRAMES-1:0] valid_q;
	rank_t                 rank_q [MAX_FRAMES];
	page_t                 page_q [MAX_FRAMES];
	cnt_t                  hits_q;
	cnt_t                  faults_q;
	logic                  out_valid_q;
	logic                  hit_q;
	frame_t                frame_q;
	logic                  ev_valid_q;
	page_t                 ev_page_q;

	logic [RANK_W:0] limit;
	rank_t           rank_nxt [MAX_FRAMES];

	// A decision leaves the queue when the result slot is free or being taken.
	assign pop = !q_empty && (!out_valid_q || !out_stall);

	always_comb begin
		for (int j = 0; j < MAX_FRAMES; j++) begin
			view.valid[j] = valid_q[j];
			view.page[j]  = page_q[j];
			view.rank[j]  = rank_q[j];
		end
	end

	// Promotion: frames younger than the chosen one age by one. An empty
	// frame counts as older than all others.
	always_comb begin
		limit = valid_q[pop_data.frame] ? {1'b0, rank_q[pop_data.frame]}
		                                : (RANK_W + 1)'(MAX_FRAMES + 1);
		for (int j = 0; j < MAX_FRAMES; j++) begin
			if (FRAME_W'(j) == pop_data.frame) rank_nxt[j] = '0;
			else if (valid_q[j] && ({1'b0, rank_q[j]} < limit))
				rank_nxt[j] = rank_q[j] + RANK_W'(1);
			else rank_nxt[j] = rank_q[j];
		end
	end

	// Table control state, totals and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < MAX_FRAMES; j++) rank_q[j] <= '0;
		end else begin
			if (pop) begin
				valid_q[pop_data.frame] <= 1'b1;
				for (int j = 0; j < MAX_FRAMES; j++) rank_q[j] <= rank_nxt[j];
				if (pop_data.hit) begin
					if (hits_q != '1) hits_q <= hits_q + CNT_W'(1);
				end else begin
					if (faults_q != '1) faults_q <= faults_q + CNT_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			page_q[pop_data.frame] <= pop_data.page;
			hit_q      <= pop_data.hit;
			frame_q    <= pop_data.frame;
			ev_valid_q <= pop_data.ev_valid;
			ev_page_q  <= pop_data.ev_page;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_count     = hits_q;
	assign fault_count   = faults_q;

endmodule

// File: sv/lru_page_replacement.sv
// Top level of the LRU page replacement block: configuration register and
// the front end, decision queue and back end. Depends on lrupr_pkg.
//
// Usage:
// Requests arrive on in_valid/in_stall with the page number on page; a
// transaction completes at an edge where in_valid is high and in_stall low.
// Results leave on out_valid/out_stall, one per request, in request order.
// The frames_in_use register is written through cfg_valid/cfg_ready/cfg_data
// (cfg_ready is always high); write it only while no request is in flight.
// A request is registered in the front end, classified into the decision queue
// and then registered as a result by the back end. When requests follow without
// a gap, a request accepted next waits for the previous decision to leave the queue.
// The front end takes a new request as it passes the previous decision to the
// queue, but classifies it only after the back end has taken that decision out
// of the queue, so the lookup always sees the updated table and rank order.
// A stalled result holds its value; the back end keeps one decision queued
// and the front end holds one accepted request, then raises in_stall.
// Reset empties every frame, clears ranks and totals and sets frames_in_use
// to 16; no clearing pass is needed, the block is ready at once.
module lru_page_replacement (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  lrupr_pkg::page_t         page,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output lrupr_pkg::frame_t        frame_index,
	output logic                     evicted_valid,
	output lrupr_pkg::page_t         evicted_page,
	output lrupr_pkg::cnt_t          hit_count,
	output lrupr_pkg::cnt_t          fault_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  lrupr_pkg::act_t          cfg_data
);
	import lrupr_pkg::*;

	act_t        frames_q;
	table_view_t view;
	logic        push;
	logic        pop;
	logic        q_empty;
	decision_t   push_data;
	decision_t   pop_data;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= ACT_W'(MAX_FRAMES);
		end else if (cfg_valid && cfg_ready) begin
			frames_q <= cfg_data;
		end
	end

	lrupr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page          (page),
		.frames_in_use (frames_q),
		.view          (view),
		.q_empty       (q_empty),
		.push          (push),
		.push_data     (push_data)
	);

	lrupr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	lrupr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.pop_data      (pop_data),
		.pop           (pop),
		.view          (view),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_count     (hit_count),
		.fault_count   (fault_count)
	);

	// The front end never classifies while a decision is still pending.
	a_push_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_empty)
		else $error("request classified against a stale frame table");

	// A hit never reports an eviction.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_data.hit) |-> !pop_data.ev_valid)
		else $error("hit decision carries an eviction");

	// Every decision taken by the back end shows up as a result.
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("decision taken without a result");

	// The chosen frame is marked valid after the update.
	a_frame_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> view.valid[$past(pop_data.frame)])
		else $error("updated frame not marked valid");

endmodule
